>>> hdl/efla_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the line rasterizer.
// No dependencies; every other file of the block imports this package.
package efla_pkg;

    // Width of one coordinate field on the stream ports.
    localparam int FIELD_W   = 6;
    // Input beat: start_x, start_y, end_x, end_y, packed from bit 0 up.
    localparam int S_TDATA_W = 24;
    // Output beat: pixel_x, pixel_y, then zero fill to a whole byte.
    localparam int M_TDATA_W = 16;

    typedef enum logic [1:0] {
        FRONT_IDLE,
        FRONT_DIV,
        FRONT_PUSH
    } front_state_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_RUN
    } back_state_t;

    // Fill status of the command queue between the front and the back.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> hdl/efla_line_rasterizer_unit.sv
`timescale 1ns / 1ps
// Line rasterizer top level: front end, command queue and pixel stepper.
// Depends on efla_pkg, efla_front, efla_queue and efla_back.
//
//  Channel  | Direction | Beat carries
//  ---------+-----------+------------------------------------------------
//  s_axis   | in        | one line: start_x, start_y, end_x, end_y
//  m_axis   | out       | one pixel: pixel_x, pixel_y; tlast on the last one
//
// For each line the front end accepts it, runs one divider step per quotient
// bit, and then hands the command to the queue. The back end emits
// |major delta| + 1 beats at one per cycle while m_axis does not stall, and
// takes the next command from the queue in its idle state.
// aresetn is synchronous and active low; it clears the queue and both FSMs.
// A stall on m_axis freezes the stepper only; the front keeps going until
// the two-entry queue is full.
module efla_line_rasterizer_unit #(
    parameter int COORD_BITS = 6,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // start_x [5:0], start_y [11:6], end_x [17:12], end_y [23:18]
    input  logic [efla_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // pixel_x [5:0], pixel_y [11:6], zeros [15:12]
    output logic [efla_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);
    import efla_pkg::*;

    localparam int CMD_W = 2 + 3 * COORD_BITS + FRAC_BITS + 2;

    queue_status_t    q_status;
    logic             cmd_push, cmd_pop;
    logic [CMD_W-1:0] push_data, pop_data;

    efla_front #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .CMD_W     (CMD_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .q_status     (q_status),
        .cmd_push     (cmd_push),
        .cmd_data     (push_data)
    );

    efla_queue #(
        .DATA_W(CMD_W),
        .DEPTH (2)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .push_data(push_data),
        .pop      (cmd_pop),
        .pop_data (pop_data),
        .status   (q_status)
    );

    efla_back #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .CMD_W     (CMD_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_status     (q_status),
        .cmd_data     (pop_data),
        .cmd_pop      (cmd_pop),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    // The stepper only takes a command that is really there.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> !q_status.empty)
        else $error("command popped from an empty queue");

    // Pixels of one line leave back to back when the sink keeps up.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("gap inside a line");

    // A waiting beat holds its pixel until the sink takes it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("waiting beat changed before it was taken");

endmodule

>>> hdl/efla_front.sv
`timescale 1ns / 1ps
// Front end: accepts line commands, picks the major axis and computes the
// minor-axis increment with a bit-serial divider. Depends on efla_pkg.
module efla_front #(
    parameter int COORD_BITS = 6,
    parameter int FRAC_BITS  = 16,
    parameter int CMD_W      = 2 + 3 * 6 + 16 + 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [efla_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  efla_pkg::queue_status_t        q_status,
    output logic                           cmd_push,
    output logic [CMD_W-1:0]               cmd_data
);
    import efla_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int CNT_W = $clog2(F + 1);
    localparam int INC_W = F + 2;

    front_state_t state_reg, state_next;

    logic [C-1:0]     sx, sy, ex, ey;
    logic [C:0]       dx, dy;
    logic [C-1:0]     adx, ady;
    logic             y_major;

    logic             y_major_reg, step_neg_reg, dmin_neg_reg;
    logic [C-1:0]     maj_start_reg, min_start_reg, divisor_reg;
    logic [C:0]       rem_reg, rem_next;
    logic [F:0]       quot_reg, quot_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             ge;
    logic [C:0]       diff;
    logic [C-1:0]     keep;
    logic [F:0]       quot_eff;
    logic [INC_W-1:0] inc;
    logic             accept;

    assign sx = s_axis_tdata[C-1:0];
    assign sy = s_axis_tdata[FIELD_W+C-1:FIELD_W];
    assign ex = s_axis_tdata[2*FIELD_W+C-1:2*FIELD_W];
    assign ey = s_axis_tdata[3*FIELD_W+C-1:3*FIELD_W];

    assign dx  = {1'b0, ex} - {1'b0, sx};
    assign dy  = {1'b0, ey} - {1'b0, sy};
    assign adx = dx[C] ? C'(-dx) : dx[C-1:0];
    assign ady = dy[C] ? C'(-dy) : dy[C-1:0];
    // Ties go to x as the major axis.
    assign y_major = ady > adx;

    assign accept = s_axis_tvalid && s_axis_tready;

    // One quotient bit per cycle of restoring division. The remainder stays
    // below the divisor, so after the trial subtract it fits in C bits.
    assign ge        = rem_reg >= {1'b0, divisor_reg};
    assign diff      = rem_reg - {1'b0, divisor_reg};
    assign keep      = ge ? diff[C-1:0] : rem_reg[C-1:0];
    assign rem_next  = {keep, 1'b0};
    assign quot_next = {quot_reg[F-1:0], ge};

    // A zero-length line has no step at all.
    assign quot_eff = (divisor_reg == '0) ? '0 : quot_reg;
    assign inc      = dmin_neg_reg ? INC_W'(-{1'b0, quot_eff}) : INC_W'({1'b0, quot_eff});

    assign cmd_data = {y_major_reg, step_neg_reg, maj_start_reg, min_start_reg,
                       divisor_reg, inc};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FRONT_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            y_major_reg   <= y_major;
            maj_start_reg <= y_major ? sy : sx;
            min_start_reg <= y_major ? sx : sy;
            divisor_reg   <= y_major ? ady : adx;
            step_neg_reg  <= y_major ? dy[C] : dx[C];
            dmin_neg_reg  <= y_major ? dx[C] : dy[C];
            rem_reg       <= {1'b0, (y_major ? adx : ady)};
            quot_reg      <= '0;
            cnt_reg       <= '0;
        end else if (state_reg == FRONT_DIV) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        cmd_push      = 1'b0;
        cnt_next      = cnt_reg + CNT_W'(1);
        unique case (state_reg)
            FRONT_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    state_next = FRONT_DIV;
                end
            end
            FRONT_DIV: begin
                if (cnt_reg == CNT_W'(F)) begin
                    state_next = FRONT_PUSH;
                end
            end
            FRONT_PUSH: begin
                cmd_push = 1'b1;
                if (!q_status.full) begin
                    state_next = FRONT_IDLE;
                end
            end
            default: begin
                state_next = FRONT_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/efla_queue.sv
`timescale 1ns / 1ps
// Short command queue that decouples the front end from the pixel stepper.
// Depends on efla_pkg for the status struct.
module efla_queue #(
    parameter int DATA_W = 40,
    parameter int DEPTH  = 2
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  logic [DATA_W-1:0]       push_data,
    input  logic                    pop,
    output logic [DATA_W-1:0]       pop_data,
    output efla_pkg::queue_status_t status
);
    import efla_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_push, do_pop;

    assign status.full  = count_reg == CNT_W'(DEPTH);
    assign status.empty = count_reg == '0;
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

>>> hdl/efla_back.sv
`timescale 1ns / 1ps
// Back end: steps the major axis and the fixed-point minor accumulator,
// one pixel per beat, into the output register. Depends on efla_pkg.
module efla_back #(
    parameter int COORD_BITS = 6,
    parameter int FRAC_BITS  = 16,
    parameter int CMD_W      = 2 + 3 * 6 + 16 + 2
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  efla_pkg::queue_status_t        q_status,
    input  logic [CMD_W-1:0]               cmd_data,
    output logic                           cmd_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [efla_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast
);
    import efla_pkg::*;

    localparam int C        = COORD_BITS;
    localparam int F        = FRAC_BITS;
    localparam int ACC_W    = C + F;
    localparam int INC_W    = F + 2;
    localparam int SPAN_LSB = INC_W;
    localparam int MIN_LSB  = SPAN_LSB + C;
    localparam int MAJ_LSB  = MIN_LSB + C;
    localparam int STEP_BIT = MAJ_LSB + C;
    localparam int YMAJ_BIT = STEP_BIT + 1;
    localparam logic [F-1:0] HALF_PIXEL = F'(1) << (F - 1);

    back_state_t state_reg, state_next;

    logic                    y_major_reg, step_neg_reg;
    logic [C-1:0]            maj_reg, rem_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic signed [INC_W-1:0] inc_reg;

    logic                    valid_reg, valid_next;
    logic [C-1:0]            px_reg, py_reg;
    logic                    last_reg;

    logic                    load_cmd, emit;
    logic [C-1:0]            minor;

    // Floor of the accumulator, kept to the coordinate width.
    assign minor = acc_reg[ACC_W-1:F];

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - 2 * FIELD_W)'(0), FIELD_W'(py_reg), FIELD_W'(px_reg)};
    assign m_axis_tlast  = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BACK_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_cmd) begin
            y_major_reg  <= cmd_data[YMAJ_BIT];
            step_neg_reg <= cmd_data[STEP_BIT];
            maj_reg      <= cmd_data[MAJ_LSB+C-1:MAJ_LSB];
            acc_reg      <= {cmd_data[MIN_LSB+C-1:MIN_LSB], HALF_PIXEL};
            rem_reg      <= cmd_data[SPAN_LSB+C-1:SPAN_LSB];
            inc_reg      <= cmd_data[INC_W-1:0];
        end else if (emit) begin
            maj_reg <= maj_reg + (step_neg_reg ? {C{1'b1}} : C'(1));
            acc_reg <= acc_reg + ACC_W'(inc_reg);
            rem_reg <= rem_reg - C'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            px_reg   <= y_major_reg ? minor : maj_reg;
            py_reg   <= y_major_reg ? maj_reg : minor;
            last_reg <= rem_reg == '0;
        end
    end

    always_comb begin
        state_next = state_reg;
        load_cmd   = 1'b0;
        emit       = 1'b0;
        valid_next = valid_reg && !m_axis_tready;
        unique case (state_reg)
            BACK_IDLE: begin
                if (!q_status.empty) begin
                    load_cmd   = 1'b1;
                    state_next = BACK_RUN;
                end
            end
            BACK_RUN: begin
                if (!valid_reg || m_axis_tready) begin
                    emit       = 1'b1;
                    valid_next = 1'b1;
                    if (rem_reg == '0) begin
                        state_next = BACK_IDLE;
                    end
                end
            end
            default: begin
                state_next = BACK_IDLE;
            end
        endcase
    end

    assign cmd_pop = load_cmd;

endmodule

>>> verif/tb_efla_line_rasterizer_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for efla_line_rasterizer_unit: a directed table of lines,
// then random lines, each line's pixels predicted or typed in and checked beat by beat.
// Depends on efla_pkg and the RTL of the rasterizer.
module tb_efla_line_rasterizer_unit;

    import efla_pkg::*;

    localparam int FRAC_BITS        = 16;
    localparam int ONE_PIXEL        = 1 << FRAC_BITS;
    localparam int HALF_PIXEL       = 1 << (FRAC_BITS - 1);
    localparam int RESET_CYCLES     = 12;
    localparam int RANDOM_LINES     = 76;
    localparam int QUIET_LINES      = 20;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int HOLD_TRIGGER     = 300;
    localparam int DRAIN_CYCLES     = 60;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DIRECTED_LINES   = 24;

    typedef struct packed {
        logic [FIELD_W-1:0] x;
        logic [FIELD_W-1:0] y;
        logic               last;
    } pixel_t;

    // A row with known_pixel set is a single-pixel line whose pixel is typed in.
    typedef struct packed {
        logic [FIELD_W-1:0] sx;
        logic [FIELD_W-1:0] sy;
        logic [FIELD_W-1:0] ex;
        logic [FIELD_W-1:0] ey;
        logic               known_pixel;
        logic [FIELD_W-1:0] kx;
        logic [FIELD_W-1:0] ky;
    } line_cmd_t;

    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;

    pixel_t expected_pixels[$];
    int     mismatches   = 0;
    int     pixels_seen  = 0;
    int     stall_cycles = 0;
    bit     quiet_tail   = 1'b0;
    bit     long_hold_done = 1'b0;
    int     rx_hold_left = 0;
    int     rx_run_left  = 0;

    line_cmd_t directed_lines [0:DIRECTED_LINES-1] = '{
        '{6'd0,  6'd0,  6'd0,  6'd0,  1'b1, 6'd0,  6'd0},
        '{6'd63, 6'd63, 6'd63, 6'd63, 1'b1, 6'd63, 6'd63},
        '{6'd0,  6'd63, 6'd0,  6'd63, 1'b1, 6'd0,  6'd63},
        '{6'd63, 6'd0,  6'd63, 6'd0,  1'b1, 6'd63, 6'd0},
        '{6'd42, 6'd21, 6'd42, 6'd21, 1'b1, 6'd42, 6'd21},
        '{6'd0,  6'd0,  6'd63, 6'd0,  1'b0, 6'd0,  6'd0},
        '{6'd63, 6'd5,  6'd0,  6'd5,  1'b0, 6'd0,  6'd0},
        '{6'd7,  6'd0,  6'd7,  6'd63, 1'b0, 6'd0,  6'd0},
        '{6'd7,  6'd63, 6'd7,  6'd0,  1'b0, 6'd0,  6'd0},
        '{6'd0,  6'd0,  6'd63, 6'd63, 1'b0, 6'd0,  6'd0},
        '{6'd63, 6'd63, 6'd0,  6'd0,  1'b0, 6'd0,  6'd0},
        '{6'd0,  6'd63, 6'd63, 6'd0,  1'b0, 6'd0,  6'd0},
        '{6'd63, 6'd0,  6'd0,  6'd63, 1'b0, 6'd0,  6'd0},
        '{6'd0,  6'd0,  6'd63, 6'd1,  1'b0, 6'd0,  6'd0},
        '{6'd63, 6'd1,  6'd0,  6'd0,  1'b0, 6'd0,  6'd0},
        '{6'd0,  6'd0,  6'd1,  6'd63, 1'b0, 6'd0,  6'd0},
        '{6'd1,  6'd63, 6'd0,  6'd0,  1'b0, 6'd0,  6'd0},
        '{6'd0,  6'd63, 6'd1,  6'd0,  1'b0, 6'd0,  6'd0},
        '{6'd40, 6'd40, 6'd10, 6'd30, 1'b0, 6'd0,  6'd0},
        '{6'd10, 6'd30, 6'd40, 6'd40, 1'b0, 6'd0,  6'd0},
        '{6'd20, 6'd13, 6'd10, 6'd17, 1'b0, 6'd0,  6'd0},
        '{6'd5,  6'd9,  6'd6,  6'd10, 1'b0, 6'd0,  6'd0},
        '{6'd33, 6'd12, 6'd30, 6'd50, 1'b0, 6'd0,  6'd0},
        '{6'd21, 6'd42, 6'd22, 6'd40, 1'b0, 6'd0,  6'd0}
    };

    efla_line_rasterizer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Walks the line the way the hardware does: the major axis steps by one, the
    // minor axis is a fixed-point accumulator floored by an arithmetic shift.
    function automatic void predict_line_pixels(input line_cmd_t ln);
        int     sxi, syi, d_major, d_minor, swap, step_inc, acc;
        int     major_pos, major_step, n_pix, minor_pos, abs_major, abs_minor;
        bit     steep;
        pixel_t px;
        sxi     = ln.sx;
        syi     = ln.sy;
        d_major = int'(ln.ex) - sxi;
        d_minor = int'(ln.ey) - syi;
        abs_major = (d_major < 0) ? -d_major : d_major;
        abs_minor = (d_minor < 0) ? -d_minor : d_minor;
        steep   = (abs_minor > abs_major);
        if (steep) begin
            swap    = d_minor;
            d_minor = d_major;
            d_major = swap;
            swap      = abs_minor;
            abs_minor = abs_major;
            abs_major = swap;
        end
        // Integer division here truncates toward zero, as the divider does.
        step_inc   = (d_major == 0) ? 0 : (d_minor * ONE_PIXEL) / d_major;
        major_pos  = steep ? syi : sxi;
        acc        = HALF_PIXEL + (steep ? sxi : syi) * ONE_PIXEL;
        major_step = (d_major > 0) ? 1 : -1;
        if (d_major < 0) begin
            step_inc = -step_inc;
        end
        n_pix = abs_major + 1;
        for (int k = 0; k < n_pix; k++) begin
            minor_pos = acc >>> FRAC_BITS;
            px.x    = steep ? minor_pos[FIELD_W-1:0] : major_pos[FIELD_W-1:0];
            px.y    = steep ? major_pos[FIELD_W-1:0] : minor_pos[FIELD_W-1:0];
            px.last = (k == n_pix - 1);
            expected_pixels.insert(expected_pixels.size(), px);
            acc       += step_inc;
            major_pos += major_step;
        end
    endfunction

    // End point close to a start coordinate, kept on the grid.
    function automatic logic [FIELD_W-1:0] near_coord(input logic [FIELD_W-1:0] c);
        int t;
        t = int'(c) + int'($urandom_range(8)) - 4;
        if (t < 0) t = 0;
        if (t > 63) t = 63;
        return t[FIELD_W-1:0];
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offers one line, optionally after an idle burst, and books its pixels on acceptance.
    task automatic send_line(input line_cmd_t ln);
        pixel_t px;
        if (!quiet_tail && $urandom_range(3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ln.ey, ln.ex, ln.sy, ln.sx};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        if (ln.known_pixel) begin
            px.x    = ln.kx;
            px.y    = ln.ky;
            px.last = 1'b1;
            expected_pixels.insert(expected_pixels.size(), px);
        end else begin
            predict_line_pixels(ln);
        end
    endtask

    initial begin : stimulus
        line_cmd_t ln;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_lines[i]) begin
            send_line(directed_lines[i]);
        end

        for (int i = 0; i < RANDOM_LINES; i++) begin
            if (i == RANDOM_LINES - QUIET_LINES) begin
                quiet_tail <= 1'b1;
            end
            ln             = '0;
            ln.sx          = FIELD_W'($urandom_range(63));
            ln.sy          = FIELD_W'($urandom_range(63));
            case ($urandom_range(7)) inside
                0: begin
                    ln.ex = ln.sx;
                    ln.ey = ln.sy;
                end
                [1:3]: begin
                    ln.ex = near_coord(ln.sx);
                    ln.ey = near_coord(ln.sy);
                end
                default: begin
                    ln.ex = FIELD_W'($urandom_range(63));
                    ln.ey = FIELD_W'($urandom_range(63));
                end
            endcase
            send_line(ln);
        end
        s_axis_tvalid <= 1'b0;

        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_efla_line_rasterizer_unit: clean");
        end else begin
            $display("tb_efla_line_rasterizer_unit: errors");
        end
        $finish;
    end

    // Pixel sink: random stalls, one long hold that backs the block up into its
    // input, and no new stalls once the quiet tail begins.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= rx_hold_left - 1;
        end else if (!long_hold_done && pixels_seen >= HOLD_TRIGGER) begin
            m_axis_tready  <= 1'b0;
            long_hold_done <= 1'b1;
            rx_hold_left   <= LONG_HOLD_CYCLES;
        end else if (quiet_tail || rx_run_left != 0) begin
            m_axis_tready <= 1'b1;
            if (rx_run_left != 0) begin
                rx_run_left <= rx_run_left - 1;
            end
        end else if ($urandom_range(3) == 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left  <= $urandom_range(10);
        end else begin
            m_axis_tready <= 1'b1;
            rx_run_left   <= $urandom_range(1, 20);
        end
    end

    always @(posedge aclk) begin : check_beat
        pixel_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            pixels_seen <= pixels_seen + 1;
            if (expected_pixels.size() == 0) begin
                flag_mismatch("beat with no pixel pending", int'(m_axis_tdata), 0);
            end else begin
                want = expected_pixels.pop_front();
                if (m_axis_tdata[FIELD_W-1:0] !== want.x) begin
                    flag_mismatch("pixel_x", int'(m_axis_tdata[FIELD_W-1:0]), int'(want.x));
                end
                if (m_axis_tdata[2*FIELD_W-1:FIELD_W] !== want.y) begin
                    flag_mismatch("pixel_y", int'(m_axis_tdata[2*FIELD_W-1:FIELD_W]),
                                  int'(want.y));
                end
                if (m_axis_tlast !== want.last) begin
                    flag_mismatch("tlast", int'(m_axis_tlast), int'(want.last));
                end
                if (m_axis_tdata[M_TDATA_W-1:2*FIELD_W] !== '0) begin
                    flag_mismatch("tdata fill bits",
                                  int'(m_axis_tdata[M_TDATA_W-1:2*FIELD_W]), 0);
                end
            end
        end
    end

    // Ends a hung run: counts cycles in which neither channel moves a beat.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_efla_line_rasterizer_unit: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule

>>> efla_line_rasterizer_unit.f
hdl/efla_pkg.sv
hdl/efla_front.sv
hdl/efla_queue.sv
hdl/efla_back.sv
hdl/efla_line_rasterizer_unit.sv
verif/tb_efla_line_rasterizer_unit.sv
